/* rtl/pts_pkg.sv */
// Shared types, constants and codes for the pixel tint and shade pipeline.
package pts_pkg;

  localparam int unsigned PIX_W   = 32;
  localparam int unsigned MULT_W  = 9;
  localparam int unsigned SHADE_W = 9;
  localparam int unsigned TINT_W  = 16;
  localparam int unsigned FMT_W   = 2;
  localparam int unsigned ADDR_W  = 5;

  // Pixel format codes.
  localparam logic [FMT_W-1:0] FMT_W16  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_B24  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_W32  = 2'd2;
  localparam logic [FMT_W-1:0] FMT_PASS = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SHADE      = 3'd0;
  localparam logic [2:0] REG_TINT_RED   = 3'd1;
  localparam logic [2:0] REG_TINT_GREEN = 3'd2;
  localparam logic [2:0] REG_TINT_BLUE  = 3'd3;
  localparam logic [2:0] REG_MASK_RED   = 3'd4;
  localparam logic [2:0] REG_MASK_GREEN = 3'd5;
  localparam logic [2:0] REG_MASK_BLUE  = 3'd6;
  localparam logic [2:0] REG_FORMAT     = 3'd7;

  localparam logic [9:0]  SHADE_BIAS  = 10'd100;
  localparam logic [9:0]  SHADE_LIMIT = 10'd200;
  localparam logic [PIX_W-1:0] SWAP_LIMIT = 32'h00FF_0000;
  localparam logic [PIX_W-1:0] LOW16_MASK = 32'h0000_FFFF;

  // floor(x / 100) for x up to 51000, the largest tint byte times shade,
  // is (x * 83887) >> 23, and the product still fits in 32 bits.
  localparam logic [16:0] RECIP_100   = 17'd83887;
  localparam int unsigned RECIP_SHIFT = 23;

  typedef enum logic [1:0] {
    LANE_R,
    LANE_G,
    LANE_B
  } pts_lane_t;

  // One pixel word as it moves through the channel stages.
  typedef struct packed {
    logic [PIX_W-1:0]  orig;
    logic [PIX_W-1:0]  acc;
    logic [MULT_W-1:0] mult_r;
    logic [MULT_W-1:0] mult_g;
    logic [MULT_W-1:0] mult_b;
  } pts_word_t;

endpackage

/* rtl/pts_chan.sv */
// One channel stage: scales the red, green or blue part of a pixel word.
module pts_chan (
  input  logic                         clk,
  input  logic                         rst,
  input  pts_pkg::pts_lane_t           lane,
  input  logic [pts_pkg::FMT_W-1:0]    fmt,
  input  logic [pts_pkg::PIX_W-1:0]    mask,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  pts_pkg::pts_word_t           in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pts_pkg::pts_word_t           out_word
);

  logic                           valid;
  pts_pkg::pts_word_t             word;
  pts_pkg::pts_word_t             word_next;
  logic [pts_pkg::MULT_W-1:0]     mult;
  logic [7:0]                     lane_byte;
  logic [pts_pkg::PIX_W-1:0]      operand;
  logic [40:0]                    product;
  logic [pts_pkg::PIX_W-1:0]      scaled;
  logic [pts_pkg::PIX_W-1:0]      byte_out;

  always_comb begin
    unique case (lane)
      pts_pkg::LANE_R: begin
        mult      = in_word.mult_r;
        lane_byte = in_word.orig[7:0];
      end
      pts_pkg::LANE_G: begin
        mult      = in_word.mult_g;
        lane_byte = in_word.orig[15:8];
      end
      pts_pkg::LANE_B: begin
        mult      = in_word.mult_b;
        lane_byte = in_word.orig[23:16];
      end
      default: begin
        mult      = '0;
        lane_byte = '0;
      end
    endcase
  end

  always_comb begin
    unique case (fmt)
      pts_pkg::FMT_W16: operand = in_word.orig & mask;
      pts_pkg::FMT_W32: operand = in_word.acc & mask;
      default:          operand = {24'h000000, lane_byte};
    endcase
  end

  // Products wrap at 32 bits before the divide by 256.
  assign product = {9'd0, operand} * {32'd0, mult};
  assign scaled  = {8'h00, product[31:8]};

  always_comb begin
    unique case (lane)
      pts_pkg::LANE_R: byte_out = {24'h000000, product[15:8]};
      pts_pkg::LANE_G: byte_out = {16'h0000, product[15:8], 8'h00};
      pts_pkg::LANE_B: byte_out = {8'h00, product[15:8], 16'h0000};
      default:         byte_out = '0;
    endcase
  end

  always_comb begin
    word_next = in_word;
    unique case (fmt)
      pts_pkg::FMT_W16: word_next.acc = (in_word.acc | (scaled & mask)) & pts_pkg::LOW16_MASK;
      pts_pkg::FMT_B24: word_next.acc = in_word.acc | byte_out;
      pts_pkg::FMT_W32: word_next.acc = (in_word.acc & ~mask) | (scaled & mask);
      default:          word_next.acc = in_word.acc;
    endcase
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      word <= word_next;
    end
  end

endmodule

/* rtl/pixel_tint_shade_top.sv */
// Top level of the pixel tint and shade pipeline with its register port.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  input     | in_valid/in_ready  | pixel_in[31:0]
//  output    | out_valid/out_ready| pixel_out[31:0]
//  registers | APB psel/penable   | paddr[4:0], pwdata/prdata[31:0]
//
// One pixel word is taken per clock while the output is not stalled. The
// stages are: shade and tint product, divide by 100,
// then one multiply stage each for red, green and blue.
// Every stage holds its word while the next one is full, so a stall on the
// output backs up stage by stage and bubbles are squeezed out.
// Reset clears all valid bits and loads the register defaults.
module pixel_tint_shade_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pts_pkg::PIX_W-1:0]         pixel_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pts_pkg::PIX_W-1:0]         pixel_out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pts_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration registers.
  logic signed [pts_pkg::SHADE_W-1:0] shade_percent;
  logic [pts_pkg::TINT_W-1:0]         tint_red;
  logic [pts_pkg::TINT_W-1:0]         tint_green;
  logic [pts_pkg::TINT_W-1:0]         tint_blue;
  logic [pts_pkg::PIX_W-1:0]          red_field_mask;
  logic [pts_pkg::PIX_W-1:0]          green_field_mask;
  logic [pts_pkg::PIX_W-1:0]          blue_field_mask;
  logic [pts_pkg::FMT_W-1:0]          pixel_format;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      shade_percent    <= 9'sd100;
      tint_red         <= 16'hFFFF;
      tint_green       <= 16'hFFFF;
      tint_blue        <= 16'hFFFF;
      red_field_mask   <= 32'h00FF_0000;
      green_field_mask <= 32'h0000_FF00;
      blue_field_mask  <= 32'h0000_00FF;
      pixel_format     <= pts_pkg::FMT_W32;
    end else if (wr_en) begin
      unique case (reg_idx)
        pts_pkg::REG_SHADE:      shade_percent    <= signed'(pwdata[8:0]);
        pts_pkg::REG_TINT_RED:   tint_red         <= pwdata[15:0];
        pts_pkg::REG_TINT_GREEN: tint_green       <= pwdata[15:0];
        pts_pkg::REG_TINT_BLUE:  tint_blue        <= pwdata[15:0];
        pts_pkg::REG_MASK_RED:   red_field_mask   <= pwdata;
        pts_pkg::REG_MASK_GREEN: green_field_mask <= pwdata;
        pts_pkg::REG_MASK_BLUE:  blue_field_mask  <= pwdata;
        pts_pkg::REG_FORMAT:     pixel_format     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pts_pkg::REG_SHADE:      prdata = {{23{shade_percent[8]}}, shade_percent};
      pts_pkg::REG_TINT_RED:   prdata = {16'h0000, tint_red};
      pts_pkg::REG_TINT_GREEN: prdata = {16'h0000, tint_green};
      pts_pkg::REG_TINT_BLUE:  prdata = {16'h0000, tint_blue};
      pts_pkg::REG_MASK_RED:   prdata = red_field_mask;
      pts_pkg::REG_MASK_GREEN: prdata = green_field_mask;
      pts_pkg::REG_MASK_BLUE:  prdata = blue_field_mask;
      pts_pkg::REG_FORMAT:     prdata = {30'd0, pixel_format};
      default:                 prdata = '0;
    endcase
  end

  // Shade transform: a negative shade lightens, then the value is limited.
  logic [9:0] shade_neg;
  logic [9:0] shade_raw;
  logic [7:0] shade;

  assign shade_neg = pts_pkg::SHADE_BIAS - {shade_percent[8], shade_percent};
  assign shade_raw = shade_percent[8] ? shade_neg : {1'b0, shade_percent};
  assign shade     = (shade_raw > pts_pkg::SHADE_LIMIT) ? pts_pkg::SHADE_LIMIT[7:0]
                                                        : shade_raw[7:0];

  // Stage 1: tint high byte times shade.
  logic                      v1;
  logic                      rdy1;
  logic [pts_pkg::PIX_W-1:0] pix1;
  logic [15:0]               prod_r;
  logic [15:0]               prod_g;
  logic [15:0]               prod_b;

  // Stage 2: multipliers, divided by 100, packed into the pixel word.
  logic                      v2;
  logic                      rdy2;
  pts_pkg::pts_word_t        word2;
  pts_pkg::pts_word_t        word2_next;
  logic [31:0]               quo_r;
  logic [31:0]               quo_g;
  logic [31:0]               quo_b;
  logic                      swap_rb;

  logic                      red_ready;
  logic                      red_valid;
  logic                      green_ready;
  logic                      green_valid;
  pts_pkg::pts_word_t        red_word;
  pts_pkg::pts_word_t        green_word;
  pts_pkg::pts_word_t        blue_word;

  assign rdy1     = !v1 || rdy2;
  assign rdy2     = !v2 || red_ready;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      pix1   <= pixel_in;
      prod_r <= {8'd0, tint_red[15:8]} * {8'd0, shade};
      prod_g <= {8'd0, tint_green[15:8]} * {8'd0, shade};
      prod_b <= {8'd0, tint_blue[15:8]} * {8'd0, shade};
    end
  end

  assign quo_r   = {16'd0, prod_r} * {15'd0, pts_pkg::RECIP_100};
  assign quo_g   = {16'd0, prod_g} * {15'd0, pts_pkg::RECIP_100};
  assign quo_b   = {16'd0, prod_b} * {15'd0, pts_pkg::RECIP_100};
  assign swap_rb = (pixel_format == pts_pkg::FMT_B24) && (red_field_mask >= pts_pkg::SWAP_LIMIT);

  always_comb begin
    word2_next.mult_g = quo_g[pts_pkg::RECIP_SHIFT +: pts_pkg::MULT_W];
    if (swap_rb) begin
      word2_next.mult_r = quo_b[pts_pkg::RECIP_SHIFT +: pts_pkg::MULT_W];
      word2_next.mult_b = quo_r[pts_pkg::RECIP_SHIFT +: pts_pkg::MULT_W];
    end else begin
      word2_next.mult_r = quo_r[pts_pkg::RECIP_SHIFT +: pts_pkg::MULT_W];
      word2_next.mult_b = quo_b[pts_pkg::RECIP_SHIFT +: pts_pkg::MULT_W];
    end
    unique case (pixel_format)
      pts_pkg::FMT_W16: begin
        word2_next.orig = pix1 & pts_pkg::LOW16_MASK;
        word2_next.acc  = '0;
      end
      pts_pkg::FMT_B24: begin
        word2_next.orig = pix1;
        word2_next.acc  = '0;
      end
      default: begin
        word2_next.orig = pix1;
        word2_next.acc  = pix1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      word2 <= word2_next;
    end
  end

  pts_chan u_red (
    .clk       (clk),
    .rst       (rst),
    .lane      (pts_pkg::LANE_R),
    .fmt       (pixel_format),
    .mask      (red_field_mask),
    .in_valid  (v2),
    .in_ready  (red_ready),
    .in_word   (word2),
    .out_valid (red_valid),
    .out_ready (green_ready),
    .out_word  (red_word)
  );

  logic blue_ready;

  pts_chan u_green (
    .clk       (clk),
    .rst       (rst),
    .lane      (pts_pkg::LANE_G),
    .fmt       (pixel_format),
    .mask      (green_field_mask),
    .in_valid  (red_valid),
    .in_ready  (green_ready),
    .in_word   (red_word),
    .out_valid (green_valid),
    .out_ready (blue_ready),
    .out_word  (green_word)
  );

  pts_chan u_blue (
    .clk       (clk),
    .rst       (rst),
    .lane      (pts_pkg::LANE_B),
    .fmt       (pixel_format),
    .mask      (blue_field_mask),
    .in_valid  (green_valid),
    .in_ready  (blue_ready),
    .in_word   (green_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (blue_word)
  );

  assign pixel_out = blue_word.acc;

endmodule

/* rtl/pts_check.sv */
// Port-level checks for the pixel tint and shade pipeline, bound to the top.
module pts_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [pts_pkg::PIX_W-1:0] pixel_out
);

  // The pipeline is emptied by reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("word shown on the output right after reset");

  // A free output lets every stage move, so a new word is always taken.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output is free");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_out))
    else $error("output word changed while stalled");

endmodule

bind pixel_tint_shade_top pts_check u_pts_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pixel_out (pixel_out)
);

/* sim/pixel_tint_shade_top_test.sv */
// Self-checking testbench for the pixel tint and shade pipeline.
`timescale 1ns / 100ps

module pixel_tint_shade_top_test;

  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 8;
  localparam int PHASES       = 3;
  localparam int BLOCKS       = 9;
  localparam int BLOCK_PIXELS = 50;

  typedef struct packed {
    logic [8:0]  shade;
    logic [15:0] tint_r;
    logic [15:0] tint_g;
    logic [15:0] tint_b;
    logic [31:0] mask_r;
    logic [31:0] mask_g;
    logic [31:0] mask_b;
    logic [1:0]  fmt;
  } shade_cfg_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] tinted;
  } tint_rec_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  // A write row uses reg_idx and data; a pixel row sends data as the pixel.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    logic        checked;
    logic [31:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 42;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hFFFF_FFFF, 1'b1, 32'hFFFE_FEFE},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h1234_5678, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_SHADE,      32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hFFFF_FFFF, 1'b1, 32'hFF00_0000},
    '{ROW_WRITE, pts_pkg::REG_FORMAT,     {30'd0, pts_pkg::FMT_W16}, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{ROW_WRITE, pts_pkg::REG_FORMAT,     {30'd0, pts_pkg::FMT_B24}, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{ROW_WRITE, pts_pkg::REG_SHADE,      32'h0000_0100, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h00FF_8001, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_RED,   32'h00FE_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h00FF_8001, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_TINT_RED,   32'h0000_1234, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_TINT_GREEN, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_TINT_BLUE,  32'h0000_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hAB12_3456, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_FORMAT,     {30'd0, pts_pkg::FMT_PASS}, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF},
    '{ROW_WRITE, pts_pkg::REG_FORMAT,     {30'd0, pts_pkg::FMT_W16}, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_RED,   32'h0000_F800, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_GREEN, 32'h0000_07E0, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_BLUE,  32'h0000_001F, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_SHADE,      32'h0000_00FF, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h5A5A_A5A5, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_SHADE,      32'h0000_019C, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_TINT_GREEN, 32'h0000_FF00, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h0000_FFFF, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_FORMAT,     {30'd0, pts_pkg::FMT_W32}, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_RED,   32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_GREEN, 32'h0F0F_0F0F, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_BLUE,  32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h8000_0001, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_SHADE,      32'h0000_019D, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'h7F7F_7F7F, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_SHADE,      32'h0000_0001, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_RED,   32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WRITE, pts_pkg::REG_MASK_GREEN, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, pts_pkg::REG_SHADE,      32'hCAFE_F00D, 1'b1, 32'hCAFE_F00D}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [pts_pkg::PIX_W-1:0]  pixel_in = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [pts_pkg::PIX_W-1:0]  pixel_out;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [pts_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  shade_cfg_t  shade_cfg = '{shade: 9'd100, tint_r: 16'hFFFF, tint_g: 16'hFFFF,
                             tint_b: 16'hFFFF, mask_r: 32'h00FF_0000,
                             mask_g: 32'h0000_FF00, mask_b: 32'h0000_00FF,
                             fmt: pts_pkg::FMT_W32};
  tint_rec_t   tinted_q [$];
  tint_rec_t   got_rec;
  int          err_count = 0;
  int          tx_gap_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  pixel_tint_shade_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic note_error(input string msg);
    err_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // One channel: the product is taken on 32 bits, so it wraps like the hardware.
  function automatic logic [31:0] scale_field(input logic [31:0] word,
                                              input logic [31:0] mask,
                                              input logic [8:0] mult);
    logic [31:0] prod;
    prod = (word & mask) * {23'd0, mult};
    return (prod >> 8) & mask;
  endfunction

  function automatic logic [31:0] tint_pixel(input shade_cfg_t c, input logic [31:0] pix);
    int          s;
    logic [8:0]  mr, mg, mb, swap;
    logic [7:0]  b0, b1, b2;
    logic [31:0] v;
    s = $signed(c.shade);
    // A negative shade lightens: it becomes 100 minus the shade.
    if (s < 0) s = 100 - s;
    if (s > 200) s = 200;
    mr = 9'((int'(c.tint_r[15:8]) * s) / 100);
    mg = 9'((int'(c.tint_g[15:8]) * s) / 100);
    mb = 9'((int'(c.tint_b[15:8]) * s) / 100);
    case (c.fmt)
      pts_pkg::FMT_W16: begin
        v = pix & pts_pkg::LOW16_MASK;
        return (scale_field(v, c.mask_r, mr) | scale_field(v, c.mask_g, mg) |
                scale_field(v, c.mask_b, mb)) & pts_pkg::LOW16_MASK;
      end
      pts_pkg::FMT_B24: begin
        if (c.mask_r >= pts_pkg::SWAP_LIMIT) begin
          swap = mr;
          mr = mb;
          mb = swap;
        end
        b0 = 8'((int'(pix[7:0]) * int'(mr)) >> 8);
        b1 = 8'((int'(pix[15:8]) * int'(mg)) >> 8);
        b2 = 8'((int'(pix[23:16]) * int'(mb)) >> 8);
        return {8'd0, b2, b1, b0};
      end
      pts_pkg::FMT_W32: begin
        v = pix;
        v = (v & ~c.mask_r) | scale_field(v, c.mask_r, mr);
        v = (v & ~c.mask_g) | scale_field(v, c.mask_g, mg);
        v = (v & ~c.mask_b) | scale_field(v, c.mask_b, mb);
        return v;
      end
      default: return pix;
    endcase
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      pts_pkg::REG_SHADE:      shade_cfg.shade  = data[8:0];
      pts_pkg::REG_TINT_RED:   shade_cfg.tint_r = data[15:0];
      pts_pkg::REG_TINT_GREEN: shade_cfg.tint_g = data[15:0];
      pts_pkg::REG_TINT_BLUE:  shade_cfg.tint_b = data[15:0];
      pts_pkg::REG_MASK_RED:   shade_cfg.mask_r = data;
      pts_pkg::REG_MASK_GREEN: shade_cfg.mask_g = data;
      pts_pkg::REG_MASK_BLUE:  shade_cfg.mask_b = data;
      default:                 shade_cfg.fmt    = data[1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Leaves in_valid high after acceptance so back-to-back words need no bubble.
  task automatic send_pixel(input logic [31:0] pix, input logic checked,
                            input logic [31:0] want);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tinted_q.push_back(tint_rec_t'{src: pix,
                                   tinted: checked ? want : tint_pixel(shade_cfg, pix)});
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tinted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_mask();
    logic [63:0] field;
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: begin
        field = ((64'd1 << $urandom_range(1, 8)) - 64'd1) << $urandom_range(0, 31);
        return field[31:0];
      end
      3: return $urandom_range(0, 1) ? 32'h00FF_0000 : 32'h00FE_FFFF;
      4: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_tint();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'h0000_FFFF;
      2: return 32'h0000_00FF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic load_random_setup();
    logic [8:0] shade;
    int         f;
    case ($urandom_range(0, 7))
      0: shade = 9'h100;
      1: shade = 9'h0FF;
      2: shade = 9'h000;
      3: shade = 9'd100;
      4: shade = 9'h19C;
      5: shade = 9'd200;
      default: shade = 9'($urandom_range(0, 511));
    endcase
    f = $urandom_range(0, 9);
    apb_write(pts_pkg::REG_SHADE, {23'd0, shade});
    apb_write(pts_pkg::REG_TINT_RED, pick_tint());
    apb_write(pts_pkg::REG_TINT_GREEN, pick_tint());
    apb_write(pts_pkg::REG_TINT_BLUE, pick_tint());
    apb_write(pts_pkg::REG_MASK_RED, pick_mask());
    apb_write(pts_pkg::REG_MASK_GREEN, pick_mask());
    apb_write(pts_pkg::REG_MASK_BLUE, pick_mask());
    if (f < 3) apb_write(pts_pkg::REG_FORMAT, {30'd0, pts_pkg::FMT_W16});
    else if (f < 6) apb_write(pts_pkg::REG_FORMAT, {30'd0, pts_pkg::FMT_B24});
    else if (f < 9) apb_write(pts_pkg::REG_FORMAT, {30'd0, pts_pkg::FMT_W32});
    else apb_write(pts_pkg::REG_FORMAT, {30'd0, pts_pkg::FMT_PASS});
  endtask

  // Output side: checks each word taken and decides the next ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tinted_q.size() == 0) begin
          note_error($sformatf("word 0x%08h arrived with nothing expected", pixel_out));
        end else begin
          got_rec = tinted_q.pop_front();
          if (pixel_out !== got_rec.tinted)
            note_error($sformatf("pixel 0x%08h: got 0x%08h, want 0x%08h",
                                 got_rec.src, pixel_out, got_rec.tinted));
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_gap_pct   = 19;
    rx_stall_pct = 68;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        drain_pipeline();
        apb_write(dir_rows[r].reg_idx, dir_rows[r].data);
      end else begin
        send_pixel(dir_rows[r].data, dir_rows[r].checked, dir_rows[r].want);
      end
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      tx_gap_pct   = (ph == 0) ? 19 : (ph == 1) ? 68 : 0;
      rx_stall_pct = (ph == 0) ? 68 : (ph == 1) ? 19 : 0;
      for (int blk = 0; blk < BLOCKS; blk++) begin
        drain_pipeline();
        load_random_setup();
        // Hold the output off long enough that the pipeline fills and
        // pushes back on the sender.
        if (blk == 1) hold_req <= hold_req + 1;
        for (int n = 0; n < BLOCK_PIXELS; n++) begin
          if (blk == 4 && n == BLOCK_PIXELS / 2) drain_pipeline();
          case ($urandom_range(0, 9))
            0: send_pixel(32'h0000_0000, 1'b0, 32'h0);
            1: send_pixel(32'hFFFF_FFFF, 1'b0, 32'h0);
            default: send_pixel($urandom, 1'b0, 32'h0);
          endcase
        end
      end
    end
    drain_pipeline();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
